>>> hw/rtl/oab_pkg.sv
// ----------------------------------------------------------------------------
// Overlap-add output buffer package
// Shared constants, register indexes and the issue-stage control bundle.
// ----------------------------------------------------------------------------
package oab_pkg;

  // Default values for the top-level parameters.
  localparam int STORE_DEPTH_DEF = 4096;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ACC_BITS_DEF    = 24;

  // Fixed field widths.
  localparam int IN_W     = 16;  // grain sample width on the input side
  localparam int OUT_W    = 16;  // output sample width
  localparam int LEN_W    = 12;  // grain_len and hop registers
  localparam int DELAY_W  = 13;  // delay register
  localparam int GAIN_W   = 16;  // Q2.14 gain register
  localparam int GI_W     = 11;  // grain index counter
  localparam int SCALED_W = 18;  // rounded, scaled grain sample
  localparam int GAIN_FRAC = 14;

  localparam int MAX_GRAIN = 2048;

  // Depth of the result queue in front of the output port.
  localparam int OQ_DEPTH = 3;

  // Register reset values.
  localparam logic [LEN_W-1:0]   GRAIN_LEN_RST = 12'd256;
  localparam logic [LEN_W-1:0]   HOP_RST       = 12'd64;
  localparam logic [DELAY_W-1:0] DELAY_RST     = 13'd0;
  localparam logic [GAIN_W-1:0]  GAIN_RST      = 16'd10923;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_GRAIN_LEN = 2'd0,
    REG_HOP       = 2'd1,
    REG_DELAY     = 2'd2,
    REG_GAIN      = 2'd3
  } reg_idx_t;

  // Operation codes carried in the input tuser.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Control bundle handed from the issue stage to the read-modify-write stage.
  typedef struct packed {
    logic valid;  // an item is in the read-modify-write stage
    logic rd;     // readable read: return the slot and clear it
    logic wr;     // the slot is written back
    logic ovf;    // dropped add sample
  } iss_t;

endpackage

>>> hw/rtl/oab_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read; a read of the
// address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module oab_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/oab_ctrl.sv
// ----------------------------------------------------------------------------
// Overlap-add issue stage
// Holds the configuration registers and ring pointers, decides each item's
// slot and fate, issues the store read, scales the grain sample, and runs the
// clearing pass after reset.
// ----------------------------------------------------------------------------
module oab_ctrl #(
  parameter int STORE_DEPTH = oab_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [1:0]                     cfg_index,
  input  logic [oab_pkg::GAIN_W-1:0]     cfg_data,
  input  logic                           fire,
  input  logic                           op,
  input  logic [oab_pkg::IN_W-1:0]       left_in,
  input  logic [oab_pkg::IN_W-1:0]       right_in,
  output logic                           busy,
  output logic [$clog2(STORE_DEPTH)-1:0] raddr,
  output logic                           clr_we,
  output logic [$clog2(STORE_DEPTH)-1:0] clr_addr,
  output oab_pkg::iss_t                  iss,
  output logic [$clog2(STORE_DEPTH)-1:0] s1_addr,
  output logic [oab_pkg::SCALED_W-1:0]   scaled_l,
  output logic [oab_pkg::SCALED_W-1:0]   scaled_r
);

  import oab_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = AW + 1;
  localparam int CW = ((AW > LEN_W) ? AW : LEN_W) + 2;
  localparam int PROD_W = IN_W + GAIN_W + 1;

  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(STORE_DEPTH - 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_GRAIN);

  // Configuration.
  logic [LEN_W-1:0]   grain_len;
  logic [LEN_W-1:0]   hop;
  logic [DELAY_W-1:0] delay;
  logic [GAIN_W-1:0]  gain;

  // Ring state.
  logic [AW-1:0]   read_pointer;
  logic [AW-1:0]   write_pointer;
  logic [PW-1:0]   pending_count;
  logic [GI_W-1:0] grain_index;
  logic [AW-1:0]   grain_offset;  // grain_index modulo the ring depth

  logic [AW-1:0]   read_pointer_next;
  logic [AW-1:0]   write_pointer_next;
  logic [PW-1:0]   pending_count_next;
  logic [GI_W-1:0] grain_index_next;
  logic [AW-1:0]   grain_offset_next;

  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] hop_eff;
  logic             drop;
  logic             last;
  logic             readable;
  logic [AW:0]      slot_sum;
  logic [AW-1:0]    slot;
  logic [CW-1:0]    wp_sum;
  logic [AW-1:0]    wp_adv;
  logic [CW-1:0]    room_need;

  iss_t iss_next;

  logic signed [PROD_W-1:0] prod_l;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] round_l;
  logic signed [PROD_W-1:0] round_r;

  // Effective grain length and hop, saturated into their legal ranges.
  always_comb begin
    if (grain_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (grain_len > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = grain_len;
    end
    if (hop == '0) begin
      hop_eff = LEN_W'(1);
    end else if (hop > len_eff) begin
      hop_eff = len_eff;
    end else begin
      hop_eff = hop;
    end
  end

  assign room_need = CW'(pending_count) + CW'(len_eff);
  assign drop      = room_need > DEPTH_C;
  assign last      = (LEN_W'(grain_index) + LEN_W'(1)) >= len_eff;
  assign readable  = CW'(pending_count) > CW'(delay);

  // Slot of an add: write pointer plus grain offset, wrapped once.
  assign slot_sum = {1'b0, write_pointer} + {1'b0, grain_offset};
  assign slot     = (slot_sum >= (AW+1)'(STORE_DEPTH)) ?
                    AW'(slot_sum - (AW+1)'(STORE_DEPTH)) : slot_sum[AW-1:0];

  // Write pointer after a kept grain; hop never exceeds the depth then.
  assign wp_sum = CW'(write_pointer) + CW'(hop_eff);
  assign wp_adv = (wp_sum >= DEPTH_C) ? AW'(wp_sum - DEPTH_C) : wp_sum[AW-1:0];

  always_comb begin
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    pending_count_next = pending_count;
    grain_index_next   = grain_index;
    grain_offset_next  = grain_offset;
    iss_next           = '0;
    raddr              = slot;
    if (op == OP_READ) begin
      raddr = read_pointer;
    end
    if (fire) begin
      iss_next.valid = 1'b1;
      if (op == OP_READ) begin
        if (readable) begin
          iss_next.rd        = 1'b1;
          iss_next.wr        = 1'b1;
          read_pointer_next  = (read_pointer == LAST_SLOT) ? '0 : read_pointer + AW'(1);
          pending_count_next = pending_count - PW'(1);
        end
      end else begin
        iss_next.wr  = !drop;
        iss_next.ovf = drop;
        if (last) begin
          grain_index_next  = '0;
          grain_offset_next = '0;
          if (!drop) begin
            write_pointer_next = wp_adv;
            pending_count_next = PW'(CW'(pending_count) + CW'(hop_eff));
          end
        end else begin
          grain_index_next  = grain_index + GI_W'(1);
          grain_offset_next = (grain_offset == LAST_SLOT) ? '0 : grain_offset + AW'(1);
        end
      end
    end
  end

  // Q2.14 scaling with round half up; the arithmetic shift floors.
  assign prod_l  = PROD_W'($signed(left_in)) * $signed({1'b0, gain});
  assign prod_r  = PROD_W'($signed(right_in)) * $signed({1'b0, gain});
  assign round_l = (prod_l + PROD_W'(1 << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
  assign round_r = (prod_r + PROD_W'(1 << (GAIN_FRAC - 1))) >>> GAIN_FRAC;

  always_ff @(posedge clk) begin
    if (rst) begin
      grain_len     <= GRAIN_LEN_RST;
      hop           <= HOP_RST;
      delay         <= DELAY_RST;
      gain          <= GAIN_RST;
      read_pointer  <= '0;
      write_pointer <= '0;
      pending_count <= '0;
      grain_index   <= '0;
      grain_offset  <= '0;
      iss           <= '0;
      busy          <= 1'b1;
      clr_addr      <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_GRAIN_LEN: grain_len <= cfg_data[LEN_W-1:0];
          REG_HOP:       hop       <= cfg_data[LEN_W-1:0];
          REG_DELAY:     delay     <= cfg_data[DELAY_W-1:0];
          REG_GAIN:      gain      <= cfg_data[GAIN_W-1:0];
          default:       ;
        endcase
      end
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
      pending_count <= pending_count_next;
      grain_index   <= grain_index_next;
      grain_offset  <= grain_offset_next;
      iss           <= iss_next;
      if (busy) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == LAST_SLOT) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Stage payload needs no reset.
  always_ff @(posedge clk) begin
    s1_addr  <= raddr;
    scaled_l <= round_l[SCALED_W-1:0];
    scaled_r <= round_r[SCALED_W-1:0];
  end

  assign clr_we = busy;

endmodule

>>> hw/rtl/oab_rmw.sv
// ----------------------------------------------------------------------------
// Overlap-add read-modify-write stage
// Takes the store word read for the issued item, forwards the latest write
// to the same slot, accumulates or reads out with saturation, and writes back.
// ----------------------------------------------------------------------------
module oab_rmw #(
  parameter int STORE_DEPTH = oab_pkg::STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS = oab_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = oab_pkg::ACC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  oab_pkg::iss_t                  iss,
  input  logic [$clog2(STORE_DEPTH)-1:0] addr,
  input  logic [oab_pkg::SCALED_W-1:0]   scaled_l,
  input  logic [oab_pkg::SCALED_W-1:0]   scaled_r,
  input  logic [2*ACC_BITS-1:0]          rdata,
  output logic                           we,
  output logic [$clog2(STORE_DEPTH)-1:0] waddr,
  output logic [2*ACC_BITS-1:0]          wdata,
  output logic                           res_push,
  output logic [2*oab_pkg::OUT_W+1:0]    res_word
);

  import oab_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int SW = 34;  // wide enough for any accumulator plus a scaled sample

  localparam logic signed [SW-1:0] ACC_MAX = (SW'(1) <<< (ACC_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0] ACC_MIN = -(SW'(1) <<< (ACC_BITS - 1));
  localparam logic signed [SW-1:0] SMP_MAX = (SW'(1) <<< (SAMPLE_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SMP_MIN = -(SW'(1) <<< (SAMPLE_BITS - 1));

  // Last write, kept to cover a read issued in the cycle of that write.
  logic                  wb_valid;
  logic [AW-1:0]         wb_addr;
  logic [2*ACC_BITS-1:0] wb_data;

  logic [2*ACC_BITS-1:0] cur;
  logic signed [SW-1:0]  cur_l;
  logic signed [SW-1:0]  cur_r;
  logic signed [SW-1:0]  sum_l;
  logic signed [SW-1:0]  sum_r;
  logic signed [SW-1:0]  acc_l;
  logic signed [SW-1:0]  acc_r;
  logic signed [SW-1:0]  out_l;
  logic signed [SW-1:0]  out_r;

  assign cur   = (wb_valid && (wb_addr == addr)) ? wb_data : rdata;
  assign cur_l = SW'($signed(cur[ACC_BITS-1:0]));
  assign cur_r = SW'($signed(cur[2*ACC_BITS-1:ACC_BITS]));
  assign sum_l = cur_l + SW'($signed(scaled_l));
  assign sum_r = cur_r + SW'($signed(scaled_r));

  always_comb begin
    acc_l = (sum_l > ACC_MAX) ? ACC_MAX : ((sum_l < ACC_MIN) ? ACC_MIN : sum_l);
    acc_r = (sum_r > ACC_MAX) ? ACC_MAX : ((sum_r < ACC_MIN) ? ACC_MIN : sum_r);
    out_l = (cur_l > SMP_MAX) ? SMP_MAX : ((cur_l < SMP_MIN) ? SMP_MIN : cur_l);
    out_r = (cur_r > SMP_MAX) ? SMP_MAX : ((cur_r < SMP_MIN) ? SMP_MIN : cur_r);
  end

  assign we    = iss.valid && iss.wr;
  assign waddr = addr;
  assign wdata = iss.rd ? '0 : {acc_r[ACC_BITS-1:0], acc_l[ACC_BITS-1:0]};

  // Result word: left, right, out_valid, overflow from the lowest bit up.
  assign res_push = iss.valid;
  assign res_word = iss.rd ? {1'b0, 1'b1, out_r[OUT_W-1:0], out_l[OUT_W-1:0]}
                           : {iss.ovf, 1'b0, {(2*OUT_W){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (we) begin
      wb_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      wb_addr <= addr;
      wb_data <= wdata;
    end
  end

endmodule

>>> hw/rtl/oab_out_queue.sv
// ----------------------------------------------------------------------------
// Overlap-add result queue
// Small register queue that decouples the pipeline from output back-pressure.
// ----------------------------------------------------------------------------
module oab_out_queue #(
  parameter int WIDTH = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_word,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_word,
  output logic [1:0]       count
);

  import oab_pkg::*;

  localparam logic [1:0] LAST_IDX = 2'(OQ_DEPTH - 1);

  logic [WIDTH-1:0] entry [OQ_DEPTH];
  logic [1:0]       wr_idx;
  logic [1:0]       rd_idx;
  logic             pop;

  assign out_valid = count != 2'd0;
  assign out_word  = entry[rd_idx];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= (wr_idx == LAST_IDX) ? '0 : wr_idx + 2'd1;
      end
      if (pop) begin
        rd_idx <= (rd_idx == LAST_IDX) ? '0 : rd_idx + 2'd1;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_idx] <= push_word;
    end
  end

endmodule

>>> hw/rtl/overlap_add_output_buffer.sv
// ----------------------------------------------------------------------------
// Overlap-add output buffer
// Stereo overlap-add synthesis ring: grain samples are gain-scaled and
// accumulated into a ring store, and output samples are read out in order.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Word contents
//  s_axis    in         tvalid / tready      tdata: left_in, right_in; tuser: op
//  m_axis    out        tvalid / tready      tdata: left_out, right_out;
//                                            tuser: out_valid, overflow
//  cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Every input word yields exactly one output word. Words are accepted one per
// cycle while s_axis_tready is high; the store's registered read returns in the
// cycle after acceptance, the read-modify-write and the write-back finish in
// that same cycle, and the result word is registered into the result queue,
// which offers the words on m_axis in order. The previous write is forwarded
// when the next word hits the same slot.
// After reset a clearing pass zeroes the store, one entry per cycle;
// s_axis_tready stays low during it, while configuration writes are taken
// throughout the pass. When m_axis stalls, a three-word result queue
// absorbs the words in flight, and s_axis_tready drops as soon as the queued
// words plus the word in flight would fill it.
//
module overlap_add_output_buffer #(
  parameter int STORE_DEPTH = oab_pkg::STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS = oab_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = oab_pkg::ACC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [2*oab_pkg::IN_W-1:0]    s_axis_tdata,   // left_in, right_in
  input  logic                          s_axis_tuser,   // op
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [2*oab_pkg::OUT_W-1:0]   m_axis_tdata,   // left_out, right_out
  output logic [1:0]                    m_axis_tuser,   // out_valid, overflow
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [oab_pkg::GAIN_W-1:0]    cfg_data
);

  import oab_pkg::*;

  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int RES_W  = 2 * OUT_W + 2;

  logic                  fire;
  logic                  busy;
  logic [AW-1:0]         raddr;
  logic                  clr_we;
  logic [AW-1:0]         clr_addr;
  iss_t                  iss;
  logic [AW-1:0]         s1_addr;
  logic [SCALED_W-1:0]   scaled_l;
  logic [SCALED_W-1:0]   scaled_r;
  logic [2*ACC_BITS-1:0] rdata;

  logic                  rmw_we;
  logic [AW-1:0]         rmw_waddr;
  logic [2*ACC_BITS-1:0] rmw_wdata;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [2*ACC_BITS-1:0] ram_wdata;

  logic                  res_push;
  logic [RES_W-1:0]      res_word;
  logic [RES_W-1:0]      q_word;
  logic [1:0]            q_count;

  // Accept only while the queue has room for every word still in flight.
  assign s_axis_tready = !busy && ((3'(q_count) + 3'(iss.valid)) < 3'(OQ_DEPTH));
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  oab_ctrl #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .op        (s_axis_tuser),
    .left_in   (s_axis_tdata[IN_W-1:0]),
    .right_in  (s_axis_tdata[2*IN_W-1:IN_W]),
    .busy      (busy),
    .raddr     (raddr),
    .clr_we    (clr_we),
    .clr_addr  (clr_addr),
    .iss       (iss),
    .s1_addr   (s1_addr),
    .scaled_l  (scaled_l),
    .scaled_r  (scaled_r)
  );

  // The clearing pass and the pipeline never write in the same cycle.
  assign ram_we    = clr_we || rmw_we;
  assign ram_waddr = clr_we ? clr_addr : rmw_waddr;
  assign ram_wdata = clr_we ? '0 : rmw_wdata;

  oab_ram #(
    .WIDTH (2 * ACC_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  oab_rmw #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_BITS    (ACC_BITS)
  ) u_rmw (
    .clk      (clk),
    .rst      (rst),
    .iss      (iss),
    .addr     (s1_addr),
    .scaled_l (scaled_l),
    .scaled_r (scaled_r),
    .rdata    (rdata),
    .we       (rmw_we),
    .waddr    (rmw_waddr),
    .wdata    (rmw_wdata),
    .res_push (res_push),
    .res_word (res_word)
  );

  oab_out_queue #(
    .WIDTH (RES_W)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_word (res_word),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (q_word),
    .count     (q_count)
  );

  assign m_axis_tdata = q_word[2*OUT_W-1:0];
  assign m_axis_tuser = q_word[RES_W-1:2*OUT_W];

endmodule
